// File: hdl/rvse_pkg.sv
// Shared types, codes and constants of the register VM step engine.
// Used by every module of the block but rvse_ram; depends on nothing.
package rvse_pkg;

  localparam int unsigned WordW       = 32;
  localparam int unsigned MemDepthDef = 1024;
  localparam int unsigned NumRegs     = 8;
  localparam int unsigned RegIdxW     = 3;
  localparam int unsigned HostAddrW   = 10;
  localparam int unsigned PcOutW      = 10;
  localparam int unsigned SpOutW      = 11;
  localparam int unsigned InstrWords  = 3;

  // Opcode words
  localparam logic [WordW-1:0] OpHalt  = 32'd0;
  localparam logic [WordW-1:0] OpLoad  = 32'd1;
  localparam logic [WordW-1:0] OpStore = 32'd2;
  localparam logic [WordW-1:0] OpAdd   = 32'd3;
  localparam logic [WordW-1:0] OpSub   = 32'd4;
  localparam logic [WordW-1:0] OpMul   = 32'd5;
  localparam logic [WordW-1:0] OpDiv   = 32'd6;
  localparam logic [WordW-1:0] OpJmp   = 32'd7;
  localparam logic [WordW-1:0] OpJz    = 32'd8;
  localparam logic [WordW-1:0] OpCall  = 32'd9;
  localparam logic [WordW-1:0] OpRet   = 32'd10;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HALT    = 3'd1,
    ST_DIVZERO = 3'd2,
    ST_BADOP   = 3'd3,
    ST_BADREG  = 3'd4,
    ST_BADADDR = 3'd5
  } stop_e;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_EXEC  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    K_LOAD  = 3'd0,
    K_STORE = 3'd1,
    K_ARITH = 3'd2,
    K_DIV   = 3'd3,
    K_FLOW  = 3'd4,
    K_CALL  = 3'd5,
    K_RET   = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    MA_HOST = 3'd0,
    MA_PC0  = 3'd1,
    MA_PC1  = 3'd2,
    MA_PC2  = 3'd3,
    MA_B    = 3'd4,
    MA_SP   = 3'd5,
    MA_SPUP = 3'd6
  } asel_e;

  typedef enum logic [1:0] {
    WS_HOST  = 2'd0,
    WS_REG_A = 2'd1,
    WS_RET   = 2'd2
  } wsel_e;

  typedef enum logic [1:0] {
    RS_A   = 2'd0,
    RS_B   = 2'd1,
    RS_SEL = 2'd2
  } rsel_e;

  typedef enum logic [1:0] {
    RR_ALU = 2'd0,
    RR_MEM = 2'd1,
    RR_DIV = 2'd2
  } rsrc_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic  capture;
    logic  mem_we;
    logic  mem_re;
    asel_e asel;
    wsel_e wsel;
    logic  ld_op;
    logic  ld_a;
    logic  ld_b;
    logic  ld_ra;
    logic  ld_rb;
    logic  ld_rdw;
    logic  rf_re;
    logic  rf_we;
    rsel_e rsel;
    logic  ld_res;
    rsrc_e rsrc;
    logic  div_start;
    logic  finish;
    logic  stop_ld;
    stop_e stop_code;
    logic  out_load;
  } ctl_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    action_e action;
    logic    host_ok;
    logic    stopped;
    logic    fetch_ok;
    stop_e   chk_code;
    kind_e   kind;
    logic    ret_bad;
    logic    div_done;
  } sts_t;

endpackage

// File: hdl/register_vm_step_engine_top.sv
// Top level of the register VM step engine: sequencer plus datapath.
// Depends on rvse_pkg, rvse_ctrl, rvse_datapath.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, action_i, address_i, | in
//          | word_value_i, reg_select_i                   |
//  out     | out_valid_o, out_ready_i, status_o, pc_now_o,| out
//          | sp_now_o, read_word_o, reg_value_o           |
//
// One item at a time; instructions fetch their words and read registers
// through single-port RAMs, and div also waits on the 32-step divider.
// Reset clears pc, stop code and register valid bits and sets sp to the
// top word at once; the word memory needs no clearing. A stalled output
// holds its beat while the block finishes the next item and waits only to
// hand over its result.
module register_vm_step_engine_top #(
  parameter int unsigned MEM_DEPTH = rvse_pkg::MemDepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         action_i,
  input  logic [rvse_pkg::HostAddrW-1:0]     address_i,
  input  logic signed [rvse_pkg::WordW-1:0]  word_value_i,
  input  logic [rvse_pkg::RegIdxW-1:0]       reg_select_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [2:0]                         status_o,
  output logic [rvse_pkg::PcOutW-1:0]        pc_now_o,
  output logic signed [rvse_pkg::SpOutW-1:0] sp_now_o,
  output logic signed [rvse_pkg::WordW-1:0]  read_word_o,
  output logic signed [rvse_pkg::WordW-1:0]  reg_value_o
);

  rvse_pkg::ctl_t ctl;
  rvse_pkg::sts_t sts;

  rvse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  rvse_datapath #(.MEM_DEPTH(MEM_DEPTH)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .action_i     (action_i),
    .address_i    (address_i),
    .word_value_i (word_value_i),
    .reg_select_i (reg_select_i),
    .status_o     (status_o),
    .pc_now_o     (pc_now_o),
    .sp_now_o     (sp_now_o),
    .read_word_o  (read_word_o),
    .reg_value_o  (reg_value_o)
  );

endmodule

// File: hdl/rvse_ram.sv
// Generic single-port RAM with registered read data.
// Stand-alone; no package needed.
module rvse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or read one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rvse_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rvse_pkg for the word width.
module rvse_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rvse_pkg::WordW-1:0] dividend_i,
  input  logic [rvse_pkg::WordW-1:0] divisor_i,
  output logic                       done_o,
  output logic [rvse_pkg::WordW-1:0] quotient_o
);

  localparam int unsigned W    = rvse_pkg::WordW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic            neg_q;
  logic [W-1:0]    rem_q;
  logic [W-1:0]    quo_q;
  logic [W-1:0]    den_q;
  logic [W-1:0]    a_mag;
  logic [W-1:0]    b_mag;
  logic [W:0]      rem_sh;
  logic [W:0]      diff;

  assign a_mag  = dividend_i[W-1] ? (~dividend_i + W'(1)) : dividend_i;
  assign b_mag  = divisor_i[W-1] ? (~divisor_i + W'(1)) : divisor_i;
  assign rem_sh = {rem_q, quo_q[W-1]};
  assign diff   = rem_sh - {1'b0, den_q};

  // Control: count down one bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(W);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  // Restoring shift-subtract on magnitudes
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
      rem_q <= '0;
      quo_q <= a_mag;
      den_q <= b_mag;
    end else if (busy_q && (cnt_q != '0)) begin
      if (!diff[W]) begin
        rem_q <= diff[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = neg_q ? (~quo_q + W'(1)) : quo_q;

endmodule

// File: hdl/rvse_datapath.sv
// Datapath: item registers, word memory, register file, ALU, divider and
// machine state (pc, sp, stop code). Depends on rvse_pkg, rvse_ram, rvse_div.
module rvse_datapath #(
  parameter int unsigned MEM_DEPTH = rvse_pkg::MemDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rvse_pkg::ctl_t                   ctl_i,
  output rvse_pkg::sts_t                   sts_o,
  input  logic [1:0]                       action_i,
  input  logic [rvse_pkg::HostAddrW-1:0]   address_i,
  input  logic signed [rvse_pkg::WordW-1:0] word_value_i,
  input  logic [rvse_pkg::RegIdxW-1:0]     reg_select_i,
  output logic [2:0]                       status_o,
  output logic [rvse_pkg::PcOutW-1:0]      pc_now_o,
  output logic signed [rvse_pkg::SpOutW-1:0] sp_now_o,
  output logic signed [rvse_pkg::WordW-1:0] read_word_o,
  output logic signed [rvse_pkg::WordW-1:0] reg_value_o
);

  localparam int unsigned W  = rvse_pkg::WordW;
  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned SW = AW + 1;
  localparam int unsigned RW = rvse_pkg::RegIdxW;
  localparam logic [W-1:0] Depth = W'(MEM_DEPTH);
  localparam logic [W-1:0] NRegs = W'(rvse_pkg::NumRegs);

  // Item registers
  logic [1:0]                     act_q;
  logic [rvse_pkg::HostAddrW-1:0] haddr_q;
  logic [W-1:0]                   hval_q;
  logic [RW-1:0]                  sel_q;
  // Instruction and operands
  logic [W-1:0] op_q, a_q, b_q, ra_q, rb_q, res_q, rdw_q;
  // Machine state
  logic [PW-1:0]        pc_q;
  logic signed [SW-1:0] sp_q;
  rvse_pkg::stop_e      stop_q;
  logic [rvse_pkg::NumRegs-1:0] rf_vld_q;
  logic [RW-1:0]        rf_ridx_q;

  logic [AW-1:0]        mem_addr;
  logic [W-1:0]         mem_wdata;
  logic [W-1:0]         mem_rdata;
  logic [RW-1:0]        rf_addr;
  logic [W-1:0]         rf_rdata;
  logic [W-1:0]         rf_val;
  logic [W-1:0]         alu_res;
  logic [W-1:0]         div_q;
  logic                 div_done;
  logic [PW-1:0]        pc_p1, pc_p2, pc_p3;
  logic signed [SW-1:0] sp_up;
  logic signed [W-1:0]  sp32, up32;
  logic                 a_reg_ok, b_reg_ok;
  rvse_pkg::stop_e      chk_code;
  rvse_pkg::kind_e      kind;
  logic [PW-1:0]        pc_d;
  logic signed [SW-1:0] sp_d;

  assign pc_p1 = pc_q + PW'(1);
  assign pc_p2 = pc_q + PW'(2);
  assign pc_p3 = pc_q + PW'(rvse_pkg::InstrWords);
  assign sp_up = sp_q + SW'(1);
  assign sp32  = W'(sp_q);
  assign up32  = sp32 + 32'sd1;

  // Word memory address and write data
  always_comb begin
    unique case (ctl_i.asel)
      rvse_pkg::MA_HOST: mem_addr = AW'(haddr_q);
      rvse_pkg::MA_PC0:  mem_addr = pc_q[AW-1:0];
      rvse_pkg::MA_PC1:  mem_addr = pc_p1[AW-1:0];
      rvse_pkg::MA_PC2:  mem_addr = pc_p2[AW-1:0];
      rvse_pkg::MA_B:    mem_addr = b_q[AW-1:0];
      rvse_pkg::MA_SP:   mem_addr = sp_q[AW-1:0];
      rvse_pkg::MA_SPUP: mem_addr = sp_up[AW-1:0];
      default:           mem_addr = pc_q[AW-1:0];
    endcase
    unique case (ctl_i.wsel)
      rvse_pkg::WS_HOST:  mem_wdata = hval_q;
      rvse_pkg::WS_REG_A: mem_wdata = ra_q;
      rvse_pkg::WS_RET:   mem_wdata = W'(pc_p3);
      default:            mem_wdata = hval_q;
    endcase
    unique case (ctl_i.rsel)
      rvse_pkg::RS_A:   rf_addr = a_q[RW-1:0];
      rvse_pkg::RS_B:   rf_addr = b_q[RW-1:0];
      rvse_pkg::RS_SEL: rf_addr = sel_q;
      default:          rf_addr = sel_q;
    endcase
  end

  rvse_ram #(.WIDTH(W), .DEPTH(MEM_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (ctl_i.mem_we),
    .re_i    (ctl_i.mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  rvse_ram #(.WIDTH(W), .DEPTH(rvse_pkg::NumRegs)) u_rf (
    .clk_i   (clk_i),
    .we_i    (ctl_i.rf_we),
    .re_i    (ctl_i.rf_re),
    .addr_i  (rf_addr),
    .wdata_i (res_q),
    .rdata_o (rf_rdata)
  );

  rvse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.div_start),
    .dividend_i (ra_q),
    .divisor_i  (rb_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Registers never written read as zero
  assign rf_val = rf_vld_q[rf_ridx_q] ? rf_rdata : '0;

  // Add, sub, mul wrap at the word width
  always_comb begin
    unique case (op_q)
      rvse_pkg::OpAdd: alu_res = ra_q + rb_q;
      rvse_pkg::OpSub: alu_res = ra_q - rb_q;
      default:         alu_res = W'(ra_q * rb_q);
    endcase
  end

  // Decode and check the fetched instruction
  assign a_reg_ok = a_q < NRegs;
  assign b_reg_ok = b_q < NRegs;

  always_comb begin
    kind     = rvse_pkg::K_FLOW;
    chk_code = rvse_pkg::ST_OK;
    unique case (op_q)
      rvse_pkg::OpHalt: chk_code = rvse_pkg::ST_HALT;
      rvse_pkg::OpLoad, rvse_pkg::OpStore: begin
        kind = (op_q == rvse_pkg::OpLoad) ? rvse_pkg::K_LOAD : rvse_pkg::K_STORE;
        if (!a_reg_ok) chk_code = rvse_pkg::ST_BADREG;
        else if (b_q >= Depth) chk_code = rvse_pkg::ST_BADADDR;
      end
      rvse_pkg::OpAdd, rvse_pkg::OpSub, rvse_pkg::OpMul: begin
        kind = rvse_pkg::K_ARITH;
        if (!a_reg_ok || !b_reg_ok) chk_code = rvse_pkg::ST_BADREG;
      end
      rvse_pkg::OpDiv: begin
        kind = rvse_pkg::K_DIV;
        if (!a_reg_ok || !b_reg_ok) chk_code = rvse_pkg::ST_BADREG;
        else if (rb_q == '0) chk_code = rvse_pkg::ST_DIVZERO;
      end
      rvse_pkg::OpJmp: begin
        if (a_q >= Depth) chk_code = rvse_pkg::ST_BADADDR;
      end
      rvse_pkg::OpJz: begin
        if (!a_reg_ok) chk_code = rvse_pkg::ST_BADREG;
        else if ((ra_q == '0) && (b_q >= Depth)) chk_code = rvse_pkg::ST_BADADDR;
      end
      rvse_pkg::OpCall: begin
        kind = rvse_pkg::K_CALL;
        if ((sp32 < 0) || (sp32 >= $signed(Depth)) || (a_q >= Depth)) begin
          chk_code = rvse_pkg::ST_BADADDR;
        end
      end
      rvse_pkg::OpRet: begin
        kind = rvse_pkg::K_RET;
        if ((up32 < 0) || (up32 >= $signed(Depth))) chk_code = rvse_pkg::ST_BADADDR;
      end
      default: chk_code = rvse_pkg::ST_BADOP;
    endcase
  end

  // Next pc and sp when an instruction retires
  always_comb begin
    pc_d = pc_p3;
    sp_d = sp_q;
    unique case (op_q)
      rvse_pkg::OpJmp:  pc_d = PW'(a_q);
      rvse_pkg::OpJz:   pc_d = (ra_q == '0) ? PW'(b_q) : pc_p3;
      rvse_pkg::OpCall: begin
        pc_d = PW'(a_q);
        sp_d = sp_q - SW'(1);
      end
      rvse_pkg::OpRet: begin
        pc_d = PW'(mem_rdata);
        sp_d = sp_up;
      end
      default: pc_d = pc_p3;
    endcase
  end

  // Machine state and register valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      sp_q     <= SW'(MEM_DEPTH - 1);
      stop_q   <= rvse_pkg::ST_OK;
      rf_vld_q <= '0;
    end else begin
      if (ctl_i.finish) begin
        pc_q <= pc_d;
        sp_q <= sp_d;
      end
      if (ctl_i.stop_ld) begin
        stop_q <= ctl_i.stop_code;
      end
      if (ctl_i.rf_we) begin
        rf_vld_q[a_q[RW-1:0]] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      act_q   <= action_i;
      haddr_q <= address_i;
      hval_q  <= word_value_i;
      sel_q   <= reg_select_i;
      rdw_q   <= '0;
    end
    if (ctl_i.ld_rdw) rdw_q <= mem_rdata;
    if (ctl_i.ld_op)  op_q  <= mem_rdata;
    if (ctl_i.ld_a)   a_q   <= mem_rdata;
    if (ctl_i.ld_b)   b_q   <= mem_rdata;
    if (ctl_i.ld_ra)  ra_q  <= rf_val;
    if (ctl_i.ld_rb)  rb_q  <= rf_val;
    if (ctl_i.rf_re)  rf_ridx_q <= rf_addr;
    if (ctl_i.ld_res) begin
      unique case (ctl_i.rsrc)
        rvse_pkg::RR_ALU: res_q <= alu_res;
        rvse_pkg::RR_MEM: res_q <= mem_rdata;
        rvse_pkg::RR_DIV: res_q <= div_q;
        default:          res_q <= alu_res;
      endcase
    end
    if (ctl_i.out_load) begin
      status_o    <= stop_q;
      pc_now_o    <= rvse_pkg::PcOutW'(pc_q);
      sp_now_o    <= rvse_pkg::SpOutW'(sp_q);
      read_word_o <= rdw_q;
      reg_value_o <= rf_val;
    end
  end

  // Status toward the sequencer
  always_comb begin
    sts_o          = '0;
    sts_o.action   = rvse_pkg::action_e'(act_q);
    sts_o.host_ok  = W'(haddr_q) < Depth;
    sts_o.stopped  = stop_q != rvse_pkg::ST_OK;
    sts_o.fetch_ok = W'(pc_p2) < Depth;
    sts_o.chk_code = chk_code;
    sts_o.kind     = kind;
    sts_o.ret_bad  = mem_rdata >= Depth;
    sts_o.div_done = div_done;
  end

endmodule

// File: hdl/rvse_ctrl.sv
// Sequencer: walks each instruction through fetch, operand read, check and retire, and handles host writes and reads.
// Depends on rvse_pkg; drives the datapath only through ctl_t.
module rvse_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  rvse_pkg::sts_t sts_i,
  output rvse_pkg::ctl_t ctl_o
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_DISP  = 15'b000000000000010,
    S_HRD   = 15'b000000000000100,
    S_F0    = 15'b000000000001000,
    S_F1    = 15'b000000000010000,
    S_F2    = 15'b000000000100000,
    S_R1    = 15'b000000001000000,
    S_R2    = 15'b000000010000000,
    S_CHK   = 15'b000000100000000,
    S_MWLD  = 15'b000001000000000,
    S_MWRET = 15'b000010000000000,
    S_DIVW  = 15'b000100000000000,
    S_WB    = 15'b001000000000000,
    S_RSEL  = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        ctl_o.asel = rvse_pkg::MA_HOST;
        ctl_o.wsel = rvse_pkg::WS_HOST;
        state_d    = S_RSEL;
        unique case (sts_i.action)
          rvse_pkg::ACT_WRITE: ctl_o.mem_we = sts_i.host_ok;
          rvse_pkg::ACT_READ: begin
            if (sts_i.host_ok) begin
              ctl_o.mem_re = 1'b1;
              state_d      = S_HRD;
            end
          end
          rvse_pkg::ACT_EXEC: begin
            if (sts_i.stopped) begin
              state_d = S_RSEL;
            end else if (!sts_i.fetch_ok) begin
              ctl_o.stop_ld   = 1'b1;
              ctl_o.stop_code = rvse_pkg::ST_BADADDR;
            end else begin
              ctl_o.mem_re = 1'b1;
              ctl_o.asel   = rvse_pkg::MA_PC0;
              state_d      = S_F0;
            end
          end
          default: state_d = S_RSEL;
        endcase
      end
      S_HRD: begin
        ctl_o.ld_rdw = 1'b1;
        state_d      = S_RSEL;
      end
      S_F0: begin
        ctl_o.ld_op  = 1'b1;
        ctl_o.mem_re = 1'b1;
        ctl_o.asel   = rvse_pkg::MA_PC1;
        state_d      = S_F1;
      end
      S_F1: begin
        ctl_o.ld_a   = 1'b1;
        ctl_o.mem_re = 1'b1;
        ctl_o.asel   = rvse_pkg::MA_PC2;
        state_d      = S_F2;
      end
      S_F2: begin
        ctl_o.ld_b  = 1'b1;
        ctl_o.rf_re = 1'b1;
        ctl_o.rsel  = rvse_pkg::RS_A;
        state_d     = S_R1;
      end
      S_R1: begin
        ctl_o.ld_ra = 1'b1;
        ctl_o.rf_re = 1'b1;
        ctl_o.rsel  = rvse_pkg::RS_B;
        state_d     = S_R2;
      end
      S_R2: begin
        ctl_o.ld_rb = 1'b1;
        state_d     = S_CHK;
      end
      S_CHK: begin
        state_d = S_RSEL;
        if (sts_i.chk_code != rvse_pkg::ST_OK) begin
          ctl_o.stop_ld   = 1'b1;
          ctl_o.stop_code = sts_i.chk_code;
        end else begin
          unique case (sts_i.kind)
            rvse_pkg::K_LOAD: begin
              ctl_o.mem_re = 1'b1;
              ctl_o.asel   = rvse_pkg::MA_B;
              state_d      = S_MWLD;
            end
            rvse_pkg::K_STORE: begin
              ctl_o.mem_we = 1'b1;
              ctl_o.asel   = rvse_pkg::MA_B;
              ctl_o.wsel   = rvse_pkg::WS_REG_A;
              ctl_o.finish = 1'b1;
            end
            rvse_pkg::K_ARITH: begin
              ctl_o.ld_res = 1'b1;
              ctl_o.rsrc   = rvse_pkg::RR_ALU;
              state_d      = S_WB;
            end
            rvse_pkg::K_DIV: begin
              ctl_o.div_start = 1'b1;
              state_d         = S_DIVW;
            end
            rvse_pkg::K_CALL: begin
              ctl_o.mem_we = 1'b1;
              ctl_o.asel   = rvse_pkg::MA_SP;
              ctl_o.wsel   = rvse_pkg::WS_RET;
              ctl_o.finish = 1'b1;
            end
            rvse_pkg::K_RET: begin
              ctl_o.mem_re = 1'b1;
              ctl_o.asel   = rvse_pkg::MA_SPUP;
              state_d      = S_MWRET;
            end
            default: ctl_o.finish = 1'b1;
          endcase
        end
      end
      S_MWLD: begin
        ctl_o.ld_res = 1'b1;
        ctl_o.rsrc   = rvse_pkg::RR_MEM;
        state_d      = S_WB;
      end
      S_MWRET: begin
        if (sts_i.ret_bad) begin
          ctl_o.stop_ld   = 1'b1;
          ctl_o.stop_code = rvse_pkg::ST_BADADDR;
        end else begin
          ctl_o.finish = 1'b1;
        end
        state_d = S_RSEL;
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          ctl_o.ld_res = 1'b1;
          ctl_o.rsrc   = rvse_pkg::RR_DIV;
          state_d      = S_WB;
        end
      end
      S_WB: begin
        ctl_o.rf_we  = 1'b1;
        ctl_o.rsel   = rvse_pkg::RS_A;
        ctl_o.finish = 1'b1;
        state_d      = S_RSEL;
      end
      S_RSEL: begin
        ctl_o.rf_re = 1'b1;
        ctl_o.rsel  = rvse_pkg::RS_SEL;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output beat holds until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_no_rw_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_o.mem_we && ctl_o.mem_re))
    else $error("word memory read and write in one cycle");

  a_div_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.div_start |=> (state_q == S_DIVW))
    else $error("divider started without waiting for it");

  a_out_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !ctl_o.out_load)
    else $error("result overwritten while still waiting");

  a_one_state_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_o.finish && ctl_o.stop_ld))
    else $error("instruction both retired and stopped");
`endif

endmodule

// File: bench/rvse_step_checker.sv
// Scoreboard for the register VM step engine: mirrors the machine state,
// predicts one result beat per input beat and compares. Depends on rvse_pkg.
`timescale 1ns / 100ps

module rvse_step_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  action_i,
  input  logic [9:0]  address_i,
  input  logic [31:0] word_value_i,
  input  logic [2:0]  reg_select_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [9:0]  pc_now_i,
  input  logic [10:0] sp_now_i,
  input  logic [31:0] read_word_i,
  input  logic [31:0] reg_value_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned MemWords = rvse_pkg::MemDepthDef;
  localparam int unsigned NRegs    = rvse_pkg::NumRegs;

  typedef struct {
    rvse_pkg::stop_e status;
    logic [9:0]      pc_now;
    logic [10:0]     sp_now;
    logic [31:0]     read_word;
    logic [31:0]     reg_value;
  } vm_report_t;

  // Mirror of the machine
  logic [31:0]     vm_mem [MemWords];
  logic [31:0]     vm_regs [NRegs];
  int unsigned     vm_pc;
  int              vm_sp;
  rvse_pkg::stop_e vm_stop;

  vm_report_t  expected_reports [$];

  // Execute the instruction at the mirrored pc; a fault only sets the stop code
  function automatic void exec_instr();
    logic [31:0] op, a, b;
    int unsigned nxt;
    int          up;
    longint      quo;
    if (vm_stop != rvse_pkg::ST_OK) return;
    if (vm_pc + 2 >= MemWords) begin
      vm_stop = rvse_pkg::ST_BADADDR;
      return;
    end
    op  = vm_mem[vm_pc];
    a   = vm_mem[vm_pc + 1];
    b   = vm_mem[vm_pc + 2];
    nxt = vm_pc + 3;
    case (op)
      rvse_pkg::OpHalt: begin
        vm_stop = rvse_pkg::ST_HALT;
        return;
      end
      rvse_pkg::OpLoad, rvse_pkg::OpStore: begin
        if (a >= NRegs) begin vm_stop = rvse_pkg::ST_BADREG; return; end
        if (b >= MemWords) begin vm_stop = rvse_pkg::ST_BADADDR; return; end
        if (op == rvse_pkg::OpLoad) vm_regs[a] = vm_mem[b];
        else vm_mem[b] = vm_regs[a];
      end
      rvse_pkg::OpAdd, rvse_pkg::OpSub, rvse_pkg::OpMul, rvse_pkg::OpDiv: begin
        if (a >= NRegs || b >= NRegs) begin
          vm_stop = rvse_pkg::ST_BADREG;
          return;
        end
        case (op)
          rvse_pkg::OpAdd: vm_regs[a] = vm_regs[a] + vm_regs[b];
          rvse_pkg::OpSub: vm_regs[a] = vm_regs[a] - vm_regs[b];
          rvse_pkg::OpMul: vm_regs[a] = vm_regs[a] * vm_regs[b];
          default: begin
            if (vm_regs[b] == 0) begin vm_stop = rvse_pkg::ST_DIVZERO; return; end
            quo = longint'($signed(vm_regs[a])) / longint'($signed(vm_regs[b]));
            vm_regs[a] = quo[31:0];
          end
        endcase
      end
      rvse_pkg::OpJmp: begin
        if (a >= MemWords) begin vm_stop = rvse_pkg::ST_BADADDR; return; end
        nxt = a;
      end
      rvse_pkg::OpJz: begin
        if (a >= NRegs) begin vm_stop = rvse_pkg::ST_BADREG; return; end
        if (vm_regs[a] == 0) begin
          if (b >= MemWords) begin vm_stop = rvse_pkg::ST_BADADDR; return; end
          nxt = b;
        end
      end
      rvse_pkg::OpCall: begin
        if (vm_sp < 0 || vm_sp >= MemWords || a >= MemWords) begin
          vm_stop = rvse_pkg::ST_BADADDR;
          return;
        end
        vm_mem[vm_sp] = vm_pc + 3;
        vm_sp--;
        nxt = a;
      end
      rvse_pkg::OpRet: begin
        up = vm_sp + 1;
        if (up < 0 || up >= MemWords) begin vm_stop = rvse_pkg::ST_BADADDR; return; end
        if (vm_mem[up] >= MemWords) begin vm_stop = rvse_pkg::ST_BADADDR; return; end
        vm_sp = up;
        nxt = vm_mem[up];
      end
      default: begin
        vm_stop = rvse_pkg::ST_BADOP;
        return;
      end
    endcase
    vm_pc = nxt;
  endfunction

  // Apply one input beat and queue the report it causes
  function automatic void apply_beat(logic [1:0] act, logic [9:0] addr,
                                     logic [31:0] val, logic [2:0] sel);
    vm_report_t rep;
    logic [31:0] rd;
    rd = '0;
    case (act)
      rvse_pkg::ACT_WRITE: vm_mem[addr] = val;
      rvse_pkg::ACT_EXEC:  exec_instr();
      rvse_pkg::ACT_READ:  rd = vm_mem[addr];
      default: ;
    endcase
    rep.status    = vm_stop;
    rep.pc_now    = vm_pc[9:0];
    rep.sp_now    = vm_sp[10:0];
    rep.read_word = rd;
    rep.reg_value = vm_regs[sel];
    expected_reports.push_back(rep);
  endfunction

  initial begin
    foreach (vm_mem[i]) vm_mem[i] = '0;
    foreach (vm_regs[i]) vm_regs[i] = '0;
    vm_pc        = 0;
    vm_sp        = MemWords - 1;
    vm_stop      = rvse_pkg::ST_OK;
    fail_count_o = 0;
  end

  assign pending_o = expected_reports.size();

  // Compare the result beat first, then take in the input beat
  always @(posedge clk_i) begin
    vm_report_t exp_rep;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o++;
        end else begin
          exp_rep = expected_reports.pop_front();
          if (status_i !== exp_rep.status) begin
            $error("status: expected %0d, got %0d", exp_rep.status, status_i);
            fail_count_o++;
          end
          if (pc_now_i !== exp_rep.pc_now) begin
            $error("pc_now: expected %0d, got %0d", exp_rep.pc_now, pc_now_i);
            fail_count_o++;
          end
          if (sp_now_i !== exp_rep.sp_now) begin
            $error("sp_now: expected %0d, got %0d", $signed(exp_rep.sp_now),
                   $signed(sp_now_i));
            fail_count_o++;
          end
          if (read_word_i !== exp_rep.read_word) begin
            $error("read_word: expected %h, got %h", exp_rep.read_word, read_word_i);
            fail_count_o++;
          end
          if (reg_value_i !== exp_rep.reg_value) begin
            $error("reg_value: expected %h, got %h", exp_rep.reg_value, reg_value_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        apply_beat(action_i, address_i, word_value_i, reg_select_i);
    end
  end

endmodule

// File: bench/tb_register_vm_step_engine_top.sv
// Testbench top for the register VM step engine: clock, reset, program
// stimulus and back pressure. Depends on rvse_pkg, the block and rvse_step_checker.
`timescale 1ns / 100ps

module tb_register_vm_step_engine_top;

  // Memory layout used by the stimulus
  localparam int unsigned LastCodePc = 597;
  localparam int unsigned DataBase   = 600;
  localparam int unsigned DataWords  = 100;
  localparam int unsigned ConstBase  = 700;
  localparam int unsigned ConstWords = 8;
  localparam int unsigned MaxDepth   = 40;
  localparam int unsigned CycleLimit = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [9:0]  address_i;
  logic [31:0] word_value_i;
  logic [2:0]  reg_select_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [9:0]  pc_now_o;
  logic [10:0] sp_now_o;
  logic [31:0] read_word_o;
  logic [31:0] reg_value_o;
  int          fail_count;
  int          pending;

  logic [31:0] const_vals [ConstWords] = '{32'd1, 32'hFFFF_FFFF, 32'd2, 32'h8000_0000,
                                          32'h7FFF_FFFF, 32'd3, 32'hFFFF_FFF9, 32'd12345};
  bit          written [1024];
  int unsigned cur_pc;
  int unsigned return_addrs [$];
  int unsigned items_sent;
  int unsigned cycles;
  int          snd_idle;
  int          rcv_idle;
  int          hold_requests;
  int          hold_seen;
  int          hold_left;

  register_vm_step_engine_top DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .address_i,
    .word_value_i, .reg_select_i, .out_valid_o, .out_ready_i, .status_o,
    .pc_now_o, .sp_now_o, .read_word_o, .reg_value_o
  );

  rvse_step_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .action_i, .address_i,
    .word_value_i, .reg_select_i, .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status_o), .pc_now_i(pc_now_o), .sp_now_i(sp_now_o),
    .read_word_i(read_word_o), .reg_value_i(reg_value_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result channel at random; a hold request forces a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_seen   <= 0;
      hold_left   <= 0;
    end else if (hold_seen != hold_requests) begin
      hold_seen   <= hold_requests;
      hold_left   <= 300;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_register_vm_step_engine_top NOT OK");
      $finish;
    end
  end

  // Offer one beat after an optional gap and hold it until accepted
  task automatic send_item(rvse_pkg::action_e act, int unsigned addr, logic [31:0] val);
    int gaps;
    gaps = 0;
    while (gaps < 20 && $urandom_range(99) < snd_idle) gaps++;
    if (gaps > 0) begin
      in_valid_i <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    address_i    <= addr[9:0];
    word_value_i <= val;
    reg_select_i <= 3'($urandom_range(7));
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    if (act == rvse_pkg::ACT_WRITE) written[addr[9:0]] = 1'b1;
    items_sent++;
  endtask

  // Pause the input until every result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Load one instruction at the current pc, execute it, follow the pc
  task automatic run_instr(logic [31:0] op, logic [31:0] a, logic [31:0] b);
    send_item(rvse_pkg::ACT_WRITE, cur_pc, op);
    send_item(rvse_pkg::ACT_WRITE, cur_pc + 1, a);
    send_item(rvse_pkg::ACT_WRITE, cur_pc + 2, b);
    send_item(rvse_pkg::ACT_EXEC, $urandom_range(1023), $urandom);
    case (op)
      rvse_pkg::OpJmp: cur_pc = a;
      rvse_pkg::OpJz: cur_pc = (a == 0) ? b : cur_pc + 3;
      rvse_pkg::OpCall: begin
        return_addrs.push_back(cur_pc + 3);
        cur_pc = a;
      end
      rvse_pkg::OpRet: if (return_addrs.size() > 0) cur_pc = return_addrs.pop_back();
      default: cur_pc = cur_pc + 3;
    endcase
  endtask

  function automatic int unsigned code_target();
    return $urandom_range(LastCodePc / 3) * 3;
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // One well-formed instruction; r0 stays zero and r7 holds a nonzero divisor
  task automatic rand_instr();
    int unsigned k;
    int unsigned src;
    k = $urandom_range(9);
    if (cur_pc + 3 > LastCodePc) k = 6;
    if (k == 8 && return_addrs.size() >= MaxDepth) k = 9;
    if (k == 9 && return_addrs.size() == 0) k = 8;
    case (k)
      0: begin
        if ($urandom_range(3) == 0)
          run_instr(rvse_pkg::OpLoad, 7, ConstBase + $urandom_range(ConstWords - 1));
        else begin
          src = $urandom_range(1) ? DataBase + $urandom_range(DataWords - 1)
                                  : ConstBase + $urandom_range(ConstWords - 1);
          run_instr(rvse_pkg::OpLoad, $urandom_range(6, 1), src);
        end
      end
      1: run_instr(rvse_pkg::OpStore, $urandom_range(7),
                   DataBase + $urandom_range(DataWords - 1));
      2: run_instr(rvse_pkg::OpAdd, $urandom_range(6, 1), $urandom_range(7));
      3: run_instr(rvse_pkg::OpSub, $urandom_range(6, 1), $urandom_range(7));
      4: run_instr(rvse_pkg::OpMul, $urandom_range(6, 1), $urandom_range(7));
      5: run_instr(rvse_pkg::OpDiv, $urandom_range(6, 1), 7);
      6: run_instr(rvse_pkg::OpJmp, code_target(), $urandom);
      7: begin
        src = $urandom_range(7);
        run_instr(rvse_pkg::OpJz, src, (src == 0) ? code_target() : cur_pc + 3);
      end
      8: run_instr(rvse_pkg::OpCall, code_target(), $urandom);
      default: run_instr(rvse_pkg::OpRet, $urandom, $urandom);
    endcase
  endtask

  // Mostly programs, with host writes, host reads and unused actions between
  task automatic random_phase(int unsigned count);
    int unsigned stop_at;
    int unsigned r;
    int unsigned addr;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 6) begin
        send_item(rvse_pkg::ACT_WRITE, DataBase + $urandom_range(DataWords - 1), $urandom);
      end else if (r < 9) begin
        send_item(rvse_pkg::ACT_WRITE, $urandom_range(LastCodePc + 2), $urandom);
      end else if (r < 16) begin
        addr = $urandom_range(1023);
        if (!written[addr]) addr = DataBase + $urandom_range(DataWords - 1);
        send_item(rvse_pkg::ACT_READ, addr, $urandom);
      end else if (r < 19) begin
        send_item(rvse_pkg::ACT_NONE, $urandom_range(1023), $urandom);
      end else rand_instr();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    action_i      = rvse_pkg::ACT_NONE;
    address_i     = '0;
    word_value_i  = '0;
    reg_select_i  = '0;
    cycles        = 0;
    snd_idle      = 0;
    rcv_idle      = 0;
    hold_requests = 0;
    items_sent    = 0;
    cur_pc        = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the data and constant areas
    for (int unsigned i = 0; i < DataWords; i++)
      send_item(rvse_pkg::ACT_WRITE, DataBase + i, pick_data());
    for (int unsigned i = 0; i < ConstWords; i++)
      send_item(rvse_pkg::ACT_WRITE, ConstBase + i, const_vals[i]);

    // Directed: overflow divide, wraps, both jz paths, call and return
    run_instr(rvse_pkg::OpLoad, 7, ConstBase + 1);
    run_instr(rvse_pkg::OpLoad, 1, ConstBase + 3);
    run_instr(rvse_pkg::OpDiv, 1, 7);
    run_instr(rvse_pkg::OpLoad, 2, ConstBase + 4);
    run_instr(rvse_pkg::OpAdd, 2, 2);
    run_instr(rvse_pkg::OpMul, 2, 2);
    run_instr(rvse_pkg::OpSub, 3, 1);
    run_instr(rvse_pkg::OpLoad, 7, ConstBase + 6);
    run_instr(rvse_pkg::OpDiv, 2, 7);
    run_instr(rvse_pkg::OpJz, 1, cur_pc + 3);
    run_instr(rvse_pkg::OpJz, 0, 300);
    run_instr(rvse_pkg::OpCall, 450, 0);
    run_instr(rvse_pkg::OpStore, 1, DataBase + 50);
    run_instr(rvse_pkg::OpRet, 0, 0);
    send_item(rvse_pkg::ACT_READ, DataBase + 50, 0);
    send_item(rvse_pkg::ACT_READ, 1023, 0);
    send_item(rvse_pkg::ACT_NONE, 1023, 32'hFFFF_FFFF);
    drain();

    // Random phases under each idling pattern, one with a long output hold
    random_phase(150);
    drain();
    snd_idle = 54;
    random_phase(150);
    drain();
    snd_idle = 0;
    rcv_idle = 54;
    random_phase(150);
    snd_idle = 25;
    rcv_idle = 25;
    random_phase(150);
    drain();
    snd_idle = 0;
    rcv_idle = 0;
    hold_requests++;
    random_phase(120);
    drain();

    // Stop the machine one way, then check that it stays stopped
    case ($urandom_range(7))
      0: run_instr(rvse_pkg::OpHalt, $urandom, $urandom);
      1: run_instr(rvse_pkg::OpDiv, 1, 0);
      2: run_instr($urandom_range(32'hFFFF_FFFF, 11), 0, 0);
      3: run_instr(rvse_pkg::OpLoad, $urandom_range(32'hFFFF_FFFF, 8), DataBase);
      4: run_instr(rvse_pkg::OpLoad, 1, $urandom_range(32'hFFFF_FFFF, 1024));
      5: run_instr(rvse_pkg::OpDiv, $urandom_range(32'hFFFF_FFFF, 8), 0);
      6: begin
        run_instr(rvse_pkg::OpJmp, 1022, 0);
        send_item(rvse_pkg::ACT_EXEC, 0, 0);
      end
      default: begin
        while (return_addrs.size() > 0) run_instr(rvse_pkg::OpRet, 0, 0);
        run_instr(rvse_pkg::OpRet, 0, 0);
      end
    endcase
    repeat (3) send_item(rvse_pkg::ACT_EXEC, 0, 0);
    send_item(rvse_pkg::ACT_WRITE, DataBase, 32'h5A5A_A5A5);
    send_item(rvse_pkg::ACT_READ, DataBase, 0);
    drain();

    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("tb_register_vm_step_engine_top OK");
    else
      $display("tb_register_vm_step_engine_top NOT OK");
    $finish;
  end

endmodule

// File: register_vm_step_engine_top.f
hdl/rvse_pkg.sv
hdl/rvse_ram.sv
hdl/rvse_div.sv
hdl/rvse_datapath.sv
hdl/rvse_ctrl.sv
hdl/register_vm_step_engine_top.sv
bench/rvse_step_checker.sv
bench/tb_register_vm_step_engine_top.sv
